>>> rtl/ata_pkg.sv
// Package for the accelerometer tilt-angle block: widths, atan table,
// square-root and CORDIC step functions, angle rounding.
// No dependencies.
package ata_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;
    localparam int SQ_FRAC         = 8;
    localparam int ACC_FRAC        = 16;
    localparam int TABLE_LEN       = 24;

    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W    = 2 * SAMPLE_BITS;
    localparam int RAD_W    = SUM_W + 2 * SQ_FRAC;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int NUM_W    = SAMPLE_BITS + SQ_FRAC;
    localparam int CORD_W   = ROOT_W + 4;
    localparam int TAB_W    = 23;
    localparam int ACC_W    = TAB_W + 2;
    localparam int TAB_IDX_W = $clog2(TABLE_LEN);
    localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ANGLE_W  = 16;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic signed [ACC_W:0] ANGLE_LIMIT = (ACC_W + 1)'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ACC_W:0] RND_HALF    = (ACC_W + 1)'(1 << (RND_SHIFT - 1));

    // atan(2^-i) in degrees, 16 fraction bits
    localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  num;
        logic              num_zero;
        logic              den_zero;
    } sq_lane_t;

    typedef struct packed {
        logic [CORD_W-1:0] xv;
        logic [CORD_W-1:0] yv;
        logic [ACC_W-1:0]  acc;
        logic              num_neg;
        logic              num_zero;
        logic              den_zero;
    } cord_lane_t;

    // one bit of restoring square root
    function automatic sq_lane_t sqrt_step(input sq_lane_t l);
        sq_lane_t o;
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] t;
        o  = l;
        r2 = {l.rem[REM_W-3:0], l.rad[RAD_W-1 -: 2]};
        t  = {1'b0, l.root, 2'b01};
        o.rad = {l.rad[RAD_W-3:0], 2'b00};
        if (r2 >= t) begin
            o.rem  = r2 - t;
            o.root = {l.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one CORDIC vectoring iteration
    function automatic cord_lane_t cord_step(input cord_lane_t c, input logic [TAB_IDX_W-1:0] i);
        cord_lane_t o;
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [ACC_W-1:0]  as;
        logic signed [ACC_W-1:0]  ang;
        o   = c;
        xs  = $signed(c.xv);
        ys  = $signed(c.yv);
        as  = $signed(c.acc);
        dx  = ys >>> i;
        dy  = xs >>> i;
        ang = $signed({2'b00, ATAN_TAB[i]});
        if (!ys[CORD_W-1]) begin
            o.xv  = xs + dx;
            o.yv  = ys - dy;
            o.acc = as + ang;
        end else begin
            o.xv  = xs - dx;
            o.yv  = ys + dy;
            o.acc = as - ang;
        end
        return o;
    endfunction

    // round to output format, clamp, apply special cases
    function automatic logic [ANGLE_W-1:0] angle_out(input cord_lane_t c);
        logic signed [ACC_W:0] rnd;
        logic signed [ACC_W:0] r;
        rnd = $signed({c.acc[ACC_W-1], c.acc}) + RND_HALF;
        r   = rnd >>> RND_SHIFT;
        if (r > ANGLE_LIMIT) begin
            r = ANGLE_LIMIT;
        end
        if (r < -ANGLE_LIMIT) begin
            r = -ANGLE_LIMIT;
        end
        if (c.num_zero) begin
            r = '0;
        end else if (c.den_zero) begin
            r = c.num_neg ? -ANGLE_LIMIT : ANGLE_LIMIT;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

>>> rtl/accel_tilt_angles.sv
// Top level: pitch and roll tilt angles from a three-axis accelerometer sample.
// Squares, pipelined square roots and unrolled CORDIC; uses ata_pkg.
//
//   channel  dir  ports                         payload
//   s_       in   s_tvalid s_tready s_tdata     accel_x, accel_y, accel_z
//   m_       out  m_tvalid m_tready m_tdata     pitch_deg, roll_deg
//                 m_tuser                       zero_vector
//
// One transfer per cycle sustained while the output is not stalled; the input transfer
// reaches m_tvalid through 44 register stages (input, squares, sums, 24 square-root bit
// stages, 16 CORDIC stages, output register).
// aresetn is synchronous, active low, and clears the valid bits only.
// A stalled output freezes the whole pipeline; a one-entry skid register
// takes one more input transfer during the stall.
module accel_tilt_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pitch_deg[15:0], roll_deg[31:16]
    output logic [0:0]  m_tuser    // zero_vector[0]
);

    localparam int SB       = ata_pkg::SAMPLE_BITS;
    localparam int NSQ      = ata_pkg::SQRT_STEPS;
    localparam int NCD      = ata_pkg::CORDIC_STAGES;
    localparam int PIPE_LEN = 3 + NSQ + NCD;

    logic               en;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [3*SB-1:0]    skid_data_reg;
    logic               src_valid;
    logic [3*SB-1:0]    src_data;
    logic [PIPE_LEN-1:0] vld_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_zero_reg;

    logic signed [SB-1:0] x0_reg, y0_reg, z0_reg;
    logic signed [SB-1:0] x1_reg, y1_reg;
    logic [ata_pkg::SQ_W-1:0]  xx1_reg, yy1_reg, zz1_reg;
    logic signed [SB-1:0] x2_reg, y2_reg;
    logic [ata_pkg::SUM_W-1:0] sum_p2_reg, sum_r2_reg;
    logic signed [2*SB-1:0] xx_full, yy_full, zz_full;

    ata_pkg::sq_lane_t   sq_init [2];
    ata_pkg::sq_lane_t   sq_reg  [NSQ][2];
    ata_pkg::cord_lane_t cd_init [2];
    ata_pkg::cord_lane_t cd_reg  [NCD][2];

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign src_valid = skid_valid_reg || s_tvalid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (en) begin
                vld_reg       <= {vld_reg[PIPE_LEN-2:0], src_valid};
                out_valid_reg <= vld_reg[PIPE_LEN-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
        end
    end

    assign xx_full = x0_reg * x0_reg;
    assign yy_full = y0_reg * y0_reg;
    assign zz_full = z0_reg * z0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg     <= $signed(src_data[SB-1:0]);
            y0_reg     <= $signed(src_data[2*SB-1:SB]);
            z0_reg     <= $signed(src_data[3*SB-1:2*SB]);
            x1_reg     <= x0_reg;
            y1_reg     <= y0_reg;
            xx1_reg    <= xx_full[ata_pkg::SQ_W-1:0];
            yy1_reg    <= yy_full[ata_pkg::SQ_W-1:0];
            zz1_reg    <= zz_full[ata_pkg::SQ_W-1:0];
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            sum_p2_reg <= ata_pkg::SUM_W'(yy1_reg) + ata_pkg::SUM_W'(zz1_reg);
            sum_r2_reg <= ata_pkg::SUM_W'(xx1_reg) + ata_pkg::SUM_W'(zz1_reg);
        end
    end

    always_comb begin
        sq_init[0].rad      = {sum_p2_reg, {(2*ata_pkg::SQ_FRAC){1'b0}}};
        sq_init[0].rem      = '0;
        sq_init[0].root     = '0;
        sq_init[0].num      = {x2_reg, {ata_pkg::SQ_FRAC{1'b0}}};
        sq_init[0].num_zero = (x2_reg == '0);
        sq_init[0].den_zero = (sum_p2_reg == '0);
        sq_init[1].rad      = {sum_r2_reg, {(2*ata_pkg::SQ_FRAC){1'b0}}};
        sq_init[1].rem      = '0;
        sq_init[1].root     = '0;
        sq_init[1].num      = {y2_reg, {ata_pkg::SQ_FRAC{1'b0}}};
        sq_init[1].num_zero = (y2_reg == '0);
        sq_init[1].den_zero = (sum_r2_reg == '0);
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (k == 0) begin
                        sq_reg[k][l] <= ata_pkg::sqrt_step(sq_init[l]);
                    end else begin
                        sq_reg[k][l] <= ata_pkg::sqrt_step(sq_reg[(k == 0) ? 0 : k-1][l]);
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_cinit
        always_comb begin
            cd_init[l].xv  = {{(ata_pkg::CORD_W-ata_pkg::ROOT_W){1'b0}}, sq_reg[NSQ-1][l].root};
            cd_init[l].yv  = {{(ata_pkg::CORD_W-ata_pkg::NUM_W)
                               {sq_reg[NSQ-1][l].num[ata_pkg::NUM_W-1]}},
                              sq_reg[NSQ-1][l].num};
            cd_init[l].acc      = '0;
            cd_init[l].num_neg  = sq_reg[NSQ-1][l].num[ata_pkg::NUM_W-1];
            cd_init[l].num_zero = sq_reg[NSQ-1][l].num_zero;
            cd_init[l].den_zero = sq_reg[NSQ-1][l].den_zero;
        end
    end

    for (genvar k = 0; k < NCD; k++) begin : g_cordic
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (k == 0) begin
                        cd_reg[k][l] <= ata_pkg::cord_step(cd_init[l], ata_pkg::TAB_IDX_W'(k));
                    end else begin
                        cd_reg[k][l] <= ata_pkg::cord_step(cd_reg[(k == 0) ? 0 : k-1][l],
                                                           ata_pkg::TAB_IDX_W'(k));
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {ata_pkg::angle_out(cd_reg[NCD-1][1]),
                             ata_pkg::angle_out(cd_reg[NCD-1][0])};
            out_zero_reg <= cd_reg[NCD-1][0].num_zero && cd_reg[NCD-1][0].den_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

`ifndef SYNTHESIS
    a_zero_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("zero sample with nonzero angle");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040) &&
                     ($signed(m_tdata[15:0]) >= -16'sd23040))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd23040) &&
                     ($signed(m_tdata[31:16]) >= -16'sd23040))
        else $error("roll out of range");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && en |=> !skid_valid_reg)
        else $error("skid entry not drained");
`endif

endmodule

>>> test/testbench.sv
// Testbench for accel_tilt_angles: directed samples, then random samples, with random idling
// on both sides. Results are checked against a pitch/roll predictor kept in this file.
// Depends on the accel_tilt_angles RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL   = 80;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam logic signed [15:0] DEG90 = 16'sd23040;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               zero_vec;
    } tilt_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        typed;
        tilt_t       want;
    } sample_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pitch_deg[15:0], roll_deg[31:16]
    logic [0:0]  m_tuser;   // zero_vector[0]

    tilt_t       angles_due[$];
    sample_row_t plan[$];
    int          err_cnt = 0;
    int          sent_cnt = 0;
    int          total_items = 0;
    bit          quiet = 0;

    accel_tilt_angles DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic longint atan_deg(input int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            default: return 115;
        endcase
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // atan(num / sqrt(a^2 + b^2)) in degrees, 8 fraction bits
    function automatic logic signed [15:0] tilt_deg(input longint num, input longint a,
                                                    input longint b);
        longint sum, xv, yv, acc, dx, dy, r;
        sum = a * a + b * b;
        if (num == 0) return 16'sd0;
        if (sum == 0) return (num > 0) ? DEG90 : -DEG90;
        xv  = longint'(root_floor(64'(sum << 16)));
        yv  = num * 256;
        acc = 0;
        for (int i = 0; i < 16; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv  = xv + dx;
                yv  = yv - dy;
                acc = acc + atan_deg(i);
            end else begin
                xv  = xv - dx;
                yv  = yv + dy;
                acc = acc - atan_deg(i);
            end
        end
        r = (acc + 128) >>> 8;
        if (r > 23040) r = 23040;
        if (r < -23040) r = -23040;
        return 16'(r);
    endfunction

    function automatic tilt_t tilt_of(input logic [47:0] d);
        tilt_t  t;
        longint x, y, z;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        if (x == 0 && y == 0 && z == 0) begin
            t = '{pitch: 16'sd0, roll: 16'sd0, zero_vec: 1'b1};
        end else begin
            t.pitch    = tilt_deg(x, y, z);
            t.roll     = tilt_deg(y, x, z);
            t.zero_vec = 1'b0;
        end
        return t;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 128)) - 16'd64;
            1: return 16'd0;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0001;
                    default: return 16'hffff;
                endcase
            end
            3: return ($urandom_range(0, 1) ? 16'd16384 : -16'sd16384)
                      + 16'($urandom_range(0, 2000)) - 16'd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                           input logic typed, input logic [15:0] p, input logic [15:0] r,
                           input logic zv);
        plan.push_back('{x: x, y: y, z: z, typed: typed,
                         want: '{pitch: p, roll: r, zero_vec: zv}});
    endtask

    task automatic report_mismatch(input string what, input logic [32:0] got,
                                   input logic [32:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // one sample transfer; the expectation is queued once the handshake is certain
    task automatic send_sample(input logic [47:0] d, input logic typed, input tilt_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        angles_due.push_back(typed ? want : tilt_of(d));
        @(posedge aclk);
        sent_cnt++;
        quiet = (sent_cnt >= total_items - QUIET_TAIL);
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        add_row(16'd0,      16'd0,      16'd0,      1, 16'd0,  16'd0,  1'b1);
        add_row(16'h7fff,   16'd0,      16'd0,      1, DEG90,  16'd0,  1'b0);
        add_row(16'h8000,   16'd0,      16'd0,      1, -DEG90, 16'd0,  1'b0);
        add_row(16'd0,      16'h7fff,   16'd0,      1, 16'd0,  DEG90,  1'b0);
        add_row(16'd0,      16'h8000,   16'd0,      1, 16'd0,  -DEG90, 1'b0);
        add_row(16'd0,      16'd0,      16'h7fff,   1, 16'd0,  16'd0,  1'b0);
        add_row(16'd0,      16'd0,      16'h8000,   1, 16'd0,  16'd0,  1'b0);
        add_row(16'd1,      16'd0,      16'd0,      1, DEG90,  16'd0,  1'b0);
        add_row(16'd0,      16'hffff,   16'd0,      1, 16'd0,  -DEG90, 1'b0);
        add_row(16'd0,      16'd0,      16'd1,      1, 16'd0,  16'd0,  1'b0);
        add_row(16'h7fff,   16'h7fff,   16'h7fff,   0, 16'd0,  16'd0,  1'b0);
        add_row(16'h8000,   16'h8000,   16'h8000,   0, 16'd0,  16'd0,  1'b0);
        add_row(16'd1,      16'd1,      16'd1,      0, 16'd0,  16'd0,  1'b0);
        add_row(16'hffff,   16'hffff,   16'hffff,   0, 16'd0,  16'd0,  1'b0);
        add_row(16'h7fff,   16'h8000,   16'd0,      0, 16'd0,  16'd0,  1'b0);
        add_row(16'd16384,  16'd0,      16'd16384,  0, 16'd0,  16'd0,  1'b0);
        add_row(16'h8000,   16'h7fff,   16'h8000,   0, 16'd0,  16'd0,  1'b0);
        add_row(16'd100,    16'd0,      -16'sd16000, 0, 16'd0, 16'd0,  1'b0);
        add_row(16'd0,      16'd200,    16'd16000,  0, 16'd0,  16'd0,  1'b0);
        add_row(16'd1,      16'hffff,   16'h7fff,   0, 16'd0,  16'd0,  1'b0);
        add_row(16'h7fff,   16'd1,      16'd1,      0, 16'd0,  16'd0,  1'b0);
        add_row(16'h8000,   16'hffff,   16'd0,      0, 16'd0,  16'd0,  1'b0);
        add_row(16'd0,      16'd0,      16'd0,      1, 16'd0,  16'd0,  1'b1);
        total_items = plan.size() + RANDOM_ITEMS;

        wait (aresetn);
        @(posedge aclk);
        for (int k = 0; k < total_items; k++) begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            if (k < plan.size()) begin
                send_sample({plan[k].z, plan[k].y, plan[k].x}, plan[k].typed, plan[k].want);
            end else begin
                send_sample({rand_axis(), rand_axis(), rand_axis()}, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        bit held;
        held = 0;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && sent_cnt >= HOLD_AT) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // signals settle between edges, so the negedge view is what the next edge samples
    always @(negedge aclk) begin
        tilt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (angles_due.size() == 0) begin
                report_mismatch("result with nothing queued", {m_tuser, m_tdata}, '0);
            end else begin
                want = angles_due.pop_front();
                if (m_tdata[15:0] !== want.pitch)
                    report_mismatch("pitch_deg", {17'd0, m_tdata[15:0]},
                                    {17'd0, want.pitch});
                if (m_tdata[31:16] !== want.roll)
                    report_mismatch("roll_deg", {17'd0, m_tdata[31:16]},
                                    {17'd0, want.roll});
                if (m_tuser[0] !== want.zero_vec)
                    report_mismatch("zero_vector", {32'd0, m_tuser[0]},
                                    {32'd0, want.zero_vec});
            end
        end
    end

    initial begin
        int still;
        still = 0;
        while (still < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                still = 0;
            else
                still++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
